### rtl/core/smpf_pkg.sv
package smpf_pkg;

	localparam int VAL_W       = 10;
	localparam int TBL_MAX     = 1 << VAL_W;
	localparam int TDATA_W     = 16;
	localparam int MAX_RESULTS = 9;
	localparam int CNT_W       = 4;

	typedef struct packed {
		logic [VAL_W-1:0] spf;
		logic [VAL_W-1:0] cof;
	} entry_t;

	typedef struct packed {
		logic             wr_en;
		logic [VAL_W-1:0] wr_addr;
		entry_t           wr_data;
		logic [VAL_W-1:0] rd_addr;
	} tbl_req_t;

endpackage

### rtl/core/smallest_prime_factor_factorizer.sv
// channel  dir  signals                         contents
// s        in   s_tvalid s_tready s_tdata       query_value [9:0]
// m        out  m_tvalid m_tready m_tdata       prime_factor [9:0]
//                         m_tlast               last_factor
//
// after reset the table of D = min(MAX_N, 1024) entries is built: one write
// per entry, then a read and check of each entry and of each multiple of
// each prime; no query is taken until it is done.
// each factor of a query takes a table read then an output load; zero, one
// and out-of-range queries skip the table read.
// a stalled output holds the factor loop; the next query is taken after the
// last factor is loaded, while that factor may still wait for m_tready.
module smallest_prime_factor_factorizer import smpf_pkg::*; #(
	parameter int MAX_N = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // query_value
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // prime_factor
	output logic               m_tlast
);

	localparam int DEPTH = (MAX_N < TBL_MAX) ? MAX_N : TBL_MAX;

	tbl_req_t         sieve_req;
	tbl_req_t         req;
	entry_t           rd_data;
	logic             table_ready;
	logic [VAL_W-1:0] q_rd_addr;
	logic [VAL_W-1:0] prime_factor;

	always_comb begin
		if (table_ready) begin
			req         = '0;
			req.rd_addr = q_rd_addr;
		end else begin
			req = sieve_req;
		end
	end

	smpf_table #(
		.DEPTH(DEPTH)
	) u_table (
		.clk    (clk),
		.req    (req),
		.rd_data(rd_data)
	);

	smpf_sieve #(
		.DEPTH(DEPTH)
	) u_sieve (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_data    (rd_data),
		.req        (sieve_req),
		.table_ready(table_ready)
	);

	smpf_query #(
		.MAX_N(MAX_N)
	) u_query (
		.clk         (clk),
		.arst_n      (arst_n),
		.table_ready (table_ready),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.query_value (s_tdata[VAL_W-1:0]),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.prime_factor(prime_factor),
		.last_factor (m_tlast),
		.rd_addr     (q_rd_addr),
		.rd_data     (rd_data)
	);

	assign m_tdata = {{(TDATA_W - VAL_W){1'b0}}, prime_factor};

endmodule

### rtl/core/smpf_table.sv
module smpf_table import smpf_pkg::*; #(
	parameter int DEPTH = 1024
) (
	input  logic     clk,
	input  tbl_req_t req,
	output entry_t   rd_data
);

	localparam int AW = $clog2(DEPTH);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr[AW-1:0]] <= req.wr_data;
		end
		rd_data <= mem[req.rd_addr[AW-1:0]];
	end

endmodule

### rtl/core/smpf_sieve.sv
module smpf_sieve import smpf_pkg::*; #(
	parameter int DEPTH = 1024
) (
	input  logic     clk,
	input  logic     arst_n,
	input  entry_t   rd_data,
	output tbl_req_t req,
	output logic     table_ready
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = AW + 1;

	typedef enum logic [2:0] {
		S_INIT,
		S_PRD,
		S_PCHK,
		S_MRD,
		S_MCHK,
		S_DONE
	} state_t;

	state_t        state_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic [CW-1:0] k_q;
	logic          ready_q;
	logic          mark;

	// multiple still holds its own index, so no smaller prime got there first
	assign mark = (state_q == S_MCHK) && (CW'(rd_data.spf) > i_q);

	always_comb begin
		req         = '0;
		req.rd_addr = (state_q == S_MRD) ? VAL_W'(j_q) : VAL_W'(i_q);
		if (state_q == S_INIT) begin
			req.wr_en        = 1'b1;
			req.wr_addr      = VAL_W'(i_q);
			req.wr_data.spf  = VAL_W'(i_q);
			req.wr_data.cof  = VAL_W'(1);
		end else begin
			req.wr_en        = mark;
			req.wr_addr      = VAL_W'(j_q);
			req.wr_data.spf  = VAL_W'(i_q);
			req.wr_data.cof  = VAL_W'(k_q);
		end
	end

	assign table_ready = ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			ready_q <= 1'b0;
		end else begin
			case (state_q)
				S_INIT: begin
					if (i_q == CW'(DEPTH - 1)) begin
						i_q     <= CW'(2);
						state_q <= S_PRD;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_PRD: begin
					if (i_q == CW'(DEPTH)) begin
						ready_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_PCHK;
					end
				end
				S_PCHK: begin
					if (CW'(rd_data.spf) == i_q) begin
						j_q     <= i_q + i_q;
						k_q     <= CW'(2);
						state_q <= S_MRD;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_PRD;
					end
				end
				S_MRD: begin
					if (j_q >= CW'(DEPTH)) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_PRD;
					end else begin
						state_q <= S_MCHK;
					end
				end
				S_MCHK: begin
					j_q     <= j_q + i_q;
					k_q     <= k_q + 1'b1;
					state_q <= S_MRD;
				end
				S_DONE: begin
					ready_q <= 1'b1;
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase
		end
	end

endmodule

### rtl/core/smpf_query.sv
module smpf_query import smpf_pkg::*; #(
	parameter int MAX_N = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             table_ready,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [VAL_W-1:0] query_value,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [VAL_W-1:0] prime_factor,
	output logic             last_factor,
	output logic [VAL_W-1:0] rd_addr,
	input  entry_t           rd_data
);

	typedef enum logic [1:0] {
		Q_IDLE,
		Q_RD,
		Q_EMIT,
		Q_SPECIAL
	} state_t;

	state_t           state_q;
	logic [VAL_W-1:0] x_q;
	logic [CNT_W-1:0] cnt_q;
	logic             valid_q;
	logic [VAL_W-1:0] factor_q;
	logic             last_q;
	logic             out_free;
	logic             special;
	logic             fin;
	logic             load;

	assign s_tready     = table_ready && (state_q == Q_IDLE);
	assign rd_addr      = x_q;
	assign m_tvalid     = valid_q;
	assign prime_factor = factor_q;
	assign last_factor  = last_q;

	assign out_free = !valid_q || m_tready;
	assign special  = (query_value < VAL_W'(2)) || (32'(query_value) >= MAX_N);
	assign fin      = (rd_data.cof <= VAL_W'(1)) || (cnt_q == CNT_W'(MAX_RESULTS - 1));
	assign load     = out_free && ((state_q == Q_EMIT) || (state_q == Q_SPECIAL));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= Q_IDLE;
			x_q      <= '0;
			cnt_q    <= '0;
			valid_q  <= 1'b0;
			factor_q <= '0;
			last_q   <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				Q_IDLE: begin
					if (s_tvalid && s_tready) begin
						x_q     <= query_value;
						cnt_q   <= '0;
						state_q <= special ? Q_SPECIAL : Q_RD;
					end
				end
				Q_RD: begin
					state_q <= Q_EMIT;
				end
				Q_EMIT: begin
					if (out_free) begin
						factor_q <= rd_data.spf;
						last_q   <= fin;
						if (fin) begin
							state_q <= Q_IDLE;
						end else begin
							x_q     <= rd_data.cof;
							cnt_q   <= cnt_q + 1'b1;
							state_q <= Q_RD;
						end
					end
				end
				Q_SPECIAL: begin
					if (out_free) begin
						factor_q <= '0;
						last_q   <= 1'b1;
						state_q  <= Q_IDLE;
					end
				end
				default: begin
					state_q <= Q_IDLE;
				end
			endcase
		end
	end

	a_mid_factor_prime: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !last_q |-> factor_q >= VAL_W'(2))
		else $error("non-final factor below two");

	a_zero_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && (factor_q < VAL_W'(2)) |-> last_q)
		else $error("zero factor without last flag");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == Q_EMIT |-> cnt_q < CNT_W'(MAX_RESULTS))
		else $error("factor count past limit");

	a_ready_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		table_ready |=> table_ready)
		else $error("table ready dropped");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second query taken while busy");

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
	import smpf_pkg::*;

	localparam int MAX_N      = 1024;
	localparam int RAND_ITEMS = 87;
	localparam int IDLE_PCT   = 13;
	localparam int HANG_LIMIT = 40000;
	localparam int DRAIN_CYC  = 40;
	localparam int SHOW_MAX   = 10;

	typedef struct packed {
		logic [VAL_W-1:0] factor;
		logic             last;
	} factor_res_t;

	typedef struct {
		logic [VAL_W-1:0] query;
		bit               typed;
		logic [VAL_W-1:0] factor;
	} query_row_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata  = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic               m_tlast;

	logic [VAL_W-1:0] spf_ref [MAX_N];
	factor_res_t      pending_factors [$];
	int               mismatches   = 0;
	int               queries_sent = 0;
	int               quiet_cycles = 0;
	bit               no_idle      = 1'b0;

	query_row_t directed [] = '{
		'{10'd0,    1'b1, 10'd0},
		'{10'd1,    1'b1, 10'd0},
		'{10'd2,    1'b1, 10'd2},
		'{10'd3,    1'b1, 10'd3},
		'{10'd1021, 1'b1, 10'd1021},
		'{10'd1019, 1'b1, 10'd1019},
		'{10'd1013, 1'b1, 10'd1013},
		'{10'd997,  1'b1, 10'd997},
		'{10'd4,    1'b0, 10'd0},
		'{10'd512,  1'b0, 10'd0},
		'{10'd768,  1'b0, 10'd0},
		'{10'd1023, 1'b0, 10'd0},
		'{10'd1022, 1'b0, 10'd0},
		'{10'd1020, 1'b0, 10'd0},
		'{10'd961,  1'b0, 10'd0},
		'{10'd729,  1'b0, 10'd0},
		'{10'd625,  1'b0, 10'd0},
		'{10'd720,  1'b0, 10'd0},
		'{10'd1008, 1'b0, 10'd0},
		'{10'd510,  1'b0, 10'd0},
		'{10'd64,   1'b0, 10'd0},
		'{10'd30,   1'b0, 10'd0},
		'{10'd9,    1'b0, 10'd0}
	};

	smallest_prime_factor_factorizer #(
		.MAX_N(MAX_N)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	always #10 clk = ~clk;

	function automatic void build_spf_ref();
		for (int i = 0; i < MAX_N; i++)
			spf_ref[i] = VAL_W'(i);
		for (int i = 2; i < MAX_N; i++) begin
			if (spf_ref[i] == VAL_W'(i)) begin
				for (int j = i + i; j < MAX_N; j += i)
					if (spf_ref[j] > VAL_W'(i))
						spf_ref[j] = VAL_W'(i);
			end
		end
	endfunction

	function automatic void expect_factor(logic [VAL_W-1:0] f, logic l);
		factor_res_t r;
		r.factor = f;
		r.last   = l;
		pending_factors.insert(pending_factors.size(), r);
	endfunction

	function automatic void push_factorization(logic [VAL_W-1:0] q);
		int unsigned rem;
		int unsigned f;
		int          n;
		rem = 32'(q);
		n = 0;
		if (rem < 2 || rem >= MAX_N) begin
			expect_factor('0, 1'b1);
			return;
		end
		while (rem > 1 && n < MAX_RESULTS) begin
			f = 32'(spf_ref[rem]);
			if (f < 2)
				f = rem;
			rem = rem / f;
			expect_factor(VAL_W'(f), (rem <= 1 || n == MAX_RESULTS - 1));
			n++;
		end
	endfunction

	task automatic report_mismatch(string what);
		mismatches++;
		if (mismatches <= SHOW_MAX)
			$display("%0t: %s", $realtime, what);
	endtask

	task automatic send_query(logic [VAL_W-1:0] q);
		while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= TDATA_W'(q);
		do @(posedge clk); while (!s_tready);
		queries_sent++;
		no_idle = (queries_sent >= 45 && queries_sent < 80);
	endtask

	function automatic logic [VAL_W-1:0] random_query();
		int unsigned v;
		int unsigned p;
		int unsigned r;
		int unsigned small_primes [4] = '{2, 3, 5, 7};
		int unsigned edges [6] = '{0, 1, 512, 1021, 1022, 1023};
		r = $urandom_range(0, 99);
		if (r < 40) begin
			v = $urandom_range(0, MAX_N - 1);
		end else if (r < 60) begin
			v = $urandom_range(0, 63);
		end else if (r < 85) begin
			v = 1;
			repeat ($urandom_range(2, 10)) begin
				p = small_primes[$urandom_range(0, 3)];
				if (v * p < MAX_N)
					v = v * p;
			end
		end else begin
			v = edges[$urandom_range(0, 5)];
		end
		return VAL_W'(v);
	endfunction

	always @(posedge clk) begin
		if (arst_n)
			m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		factor_res_t want;
		if (m_tvalid && m_tready) begin
			if (pending_factors.size() == 0) begin
				report_mismatch($sformatf("unexpected transfer: factor %0d last %0b",
					m_tdata, m_tlast));
			end else begin
				want = pending_factors.pop_front();
				if (m_tdata !== TDATA_W'(want.factor) || m_tlast !== want.last)
					report_mismatch($sformatf(
						"factor expected %0d got %0d, last expected %0b got %0b",
						want.factor, m_tdata, want.last, m_tlast));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= HANG_LIMIT) begin
			$display("smallest_prime_factor_factorizer test failed");
			$finish;
		end
	end

	initial begin
		build_spf_ref();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].typed)
				expect_factor(directed[i].factor, 1'b1);
			else
				push_factorization(directed[i].query);
			send_query(directed[i].query);
		end

		repeat (RAND_ITEMS) begin
			logic [VAL_W-1:0] q;
			q = random_query();
			push_factorization(q);
			send_query(q);
		end
		s_tvalid <= 1'b0;

		while (pending_factors.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		if (mismatches == 0 && pending_factors.size() == 0)
			$display("smallest_prime_factor_factorizer test passed");
		else
			$display("smallest_prime_factor_factorizer test failed");
		$finish;
	end

endmodule

### filelist.f
rtl/core/smpf_pkg.sv
rtl/core/smpf_table.sv
rtl/core/smpf_sieve.sv
rtl/core/smpf_query.sv
rtl/core/smallest_prime_factor_factorizer.sv
bench/tb.sv
